FILE: hdl/cst_pkg.sv
// Shared constants for the chunk slot table: defaults, opcodes and stream widths.
`timescale 1ns / 1ps
`default_nettype none
package cst_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int CHUNK_EDGE_DEF = 16;

  // Request kinds carried on the input tuser.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam int POS_W    = 32;
  localparam int SLOT_W   = 5;
  localparam int OFFSET_W = 12;

  localparam int S_DATA_W = 3 * POS_W;
  localparam int S_USER_W = 1;
  localparam int M_DATA_W = ((SLOT_W + OFFSET_W + 7) / 8) * 8;
  localparam int M_USER_W = 1;

endpackage
`default_nettype wire

FILE: hdl/cst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/chunk_slot_table_top.sv
// Top level of the chunk slot table: request decode, slot scan sequencer and result register.
//
// The block keeps SLOT_COUNT chunk slots, each a valid flag plus the aligned x/y/z chunk
// coordinates held in a small tag RAM. A request word arrives on the s_ channel: tdata
// carries the world position (x, y, z), tuser the opcode. A load claims the lowest vacant
// slot and stores the chunk coordinates; a lookup finds the lowest valid slot whose tag
// matches and reports the block offset z*EDGE*EDGE + y*EDGE + x inside that chunk.
// Every request yields exactly one result word on the m_ channel: tuser is the ok flag,
// tdata holds the slot index and the block offset (both zero when ok is low).
//
// A request is worked on alone. The sequencer walks the slots one per cycle through the shared
// tag compare and stops at the first free slot for a load or the first matching slot for a
// lookup, or else at the end of the table; the result word is then offered on the m_ channel.
// s_tready is high only while the sequencer is idle, so a new request is not accepted until
// the previous result has left the sequencer.
//
// The result word sits in an output register; a new request is accepted while it waits.
// If the receiver still stalls when the next result is ready, that result waits in the
// sequencer until the output register frees. Reset vacates every slot and empties the
// output register; the tag RAM is not cleared, since vacant slots are never compared.
`timescale 1ns / 1ps
`default_nettype none
module chunk_slot_table_top #(
  parameter int SLOT_COUNT = cst_pkg::SLOT_COUNT_DEF,
  parameter int CHUNK_EDGE = cst_pkg::CHUNK_EDGE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64]
  input  wire logic [cst_pkg::S_DATA_W-1:0] s_tdata,
  // opcode [0]
  input  wire logic [cst_pkg::S_USER_W-1:0] s_tuser,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // slot_index [4:0], block_offset [16:5], zero fill [23:17]
  output logic      [cst_pkg::M_DATA_W-1:0] m_tdata,
  // ok [0]
  output logic      [cst_pkg::M_USER_W-1:0] m_tuser
);

  import cst_pkg::*;

  localparam int EDGE_W  = $clog2(CHUNK_EDGE);
  localparam int TAG_W   = POS_W - EDGE_W;
  localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int RAM_W   = 3 * TAG_W;
  localparam int LOCAL_W = 3 * EDGE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state, state_next;

  // Request held for the duration of the scan.
  logic                req_op;
  logic [RAM_W-1:0]    req_tag;
  logic [OFFSET_W-1:0] req_off;

  logic [SLOT_COUNT-1:0] slot_valid;
  logic [CNT_W-1:0]      idx;
  logic                  pend;
  logic [IDX_W-1:0]      pend_idx;

  logic                res_ok;
  logic [IDX_W-1:0]    res_idx;
  logic [OFFSET_W-1:0] res_off;

  logic [RAM_W-1:0] ram_rdata;
  logic [IDX_W-1:0] scan_addr;
  logic             scan_live;
  logic             load_hit;
  logic             look_hit;
  logic             scan_end;
  logic             ram_we;

  logic [POS_W-1:0]          in_x, in_y, in_z;
  logic [LOCAL_W-1:0]        in_local;
  logic [LOCAL_W+OFFSET_W-1:0] in_local_wide;
  logic [IDX_W+SLOT_W-1:0]   slot_wide;

  assign in_x = s_tdata[POS_W-1:0];
  assign in_y = s_tdata[2*POS_W-1:POS_W];
  assign in_z = s_tdata[3*POS_W-1:2*POS_W];

  // In-chunk coordinates packed z:y:x are exactly z*EDGE*EDGE + y*EDGE + x.
  assign in_local      = {in_z[EDGE_W-1:0], in_y[EDGE_W-1:0], in_x[EDGE_W-1:0]};
  assign in_local_wide = {{OFFSET_W{1'b0}}, in_local};

  assign s_tready  = (state == ST_IDLE);
  assign scan_addr = idx[IDX_W-1:0];
  assign scan_live = (state == ST_SCAN) && (idx != CNT_W'(SLOT_COUNT));

  // Load: the first vacant slot met in the walk is taken.
  assign load_hit = scan_live && (req_op == OP_LOAD) && !slot_valid[scan_addr];
  assign ram_we   = load_hit;

  // Lookup: the tag read last cycle is compared against the request.
  assign look_hit = (state == ST_SCAN) && (req_op == OP_LOOKUP) && pend &&
                    slot_valid[pend_idx] && (ram_rdata == req_tag);

  assign scan_end = (state == ST_SCAN) && !scan_live && !pend;

  cst_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SLOT_COUNT)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (scan_addr),
    .wdata (req_tag),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (load_hit || look_hit || scan_end) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      pend       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (load_hit) begin
        slot_valid[scan_addr] <= 1'b1;
      end
      if (state == ST_SCAN) begin
        pend <= scan_live && (req_op == OP_LOOKUP);
      end else begin
        pend <= 1'b0;
      end
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      req_op  <= s_tuser[0];
      req_tag <= {in_z[POS_W-1:EDGE_W], in_y[POS_W-1:EDGE_W], in_x[POS_W-1:EDGE_W]};
      req_off <= in_local_wide[OFFSET_W-1:0];
      idx     <= '0;
    end else if (scan_live) begin
      idx <= idx + CNT_W'(1);
    end
    pend_idx <= scan_addr;

    if (load_hit) begin
      res_ok  <= 1'b1;
      res_idx <= scan_addr;
      res_off <= '0;
    end else if (look_hit) begin
      res_ok  <= 1'b1;
      res_idx <= pend_idx;
      res_off <= req_off;
    end else if (scan_end) begin
      res_ok  <= 1'b0;
      res_idx <= '0;
      res_off <= '0;
    end

    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tuser <= M_USER_W'(res_ok);
      m_tdata <= M_DATA_W'({res_off, slot_wide[SLOT_W-1:0]});
    end
  end

  assign slot_wide = {{SLOT_W{1'b0}}, res_idx};

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the chunk slot table: stream driver, result monitor and slot predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import cst_pkg::*;

  localparam int SLOTS        = SLOT_COUNT_DEF;
  localparam int EDGE         = CHUNK_EDGE_DEF;
  localparam logic [31:0] LOW_MASK = EDGE - 1;
  localparam int RANDOM_WORDS = 450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic        opcode;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } request_t;

  typedef struct packed {
    logic                ok;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] offset;
  } answer_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } chunk_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic [S_USER_W-1:0] s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;

  chunk_slot_table_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Predicted table contents.
  bit          slot_live [SLOTS];
  logic [31:0] slot_tag_x [SLOTS];
  logic [31:0] slot_tag_y [SLOTS];
  logic [31:0] slot_tag_z [SLOTS];

  request_t request_queue [$];
  answer_t  answers_due [$];

  // Chunks that the stimulus has loaded so far, used to aim lookups at hits.
  chunk_t loaded_chunks [$];
  int     loads_queued = 0;

  int mismatches = 0;
  int cycles = 0;
  int words_sent = 0;
  int words_seen = 0;
  int n_load = 0;
  int n_full = 0;
  int n_lookup = 0;
  int n_hit = 0;

  bit       req_taken = 1'b0;
  bit       resp_taken = 1'b0;
  bit       req_held = 1'b0;
  int       req_gap = 0;
  int       resp_stall = 0;
  request_t req_now = '0;

  // Works out the answer to one request and updates the predicted table.
  function automatic answer_t access_table(logic op, logic [S_DATA_W-1:0] word);
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    int          off;
    bit          done;
    answer_t     res;
    px = word[31:0];
    py = word[63:32];
    pz = word[95:64];
    res = '0;
    done = 1'b0;
    if (op == OP_LOAD) begin
      n_load++;
      for (int i = 0; i < SLOTS; i++) begin
        if (!done && !slot_live[i]) begin
          slot_live[i] = 1'b1;
          slot_tag_x[i] = px & ~LOW_MASK;
          slot_tag_y[i] = py & ~LOW_MASK;
          slot_tag_z[i] = pz & ~LOW_MASK;
          res.ok = 1'b1;
          res.slot = i[SLOT_W-1:0];
          done = 1'b1;
        end
      end
      if (!done) n_full++;
    end else begin
      n_lookup++;
      for (int i = 0; i < SLOTS; i++) begin
        if (!done && slot_live[i] && slot_tag_x[i] == (px & ~LOW_MASK) &&
            slot_tag_y[i] == (py & ~LOW_MASK) && slot_tag_z[i] == (pz & ~LOW_MASK)) begin
          off = int'(pz & LOW_MASK) * EDGE * EDGE + int'(py & LOW_MASK) * EDGE +
                int'(px & LOW_MASK);
          res.ok = 1'b1;
          res.slot = i[SLOT_W-1:0];
          res.offset = off[OFFSET_W-1:0];
          done = 1'b1;
        end
      end
      if (done) n_hit++;
    end
    return res;
  endfunction

  function automatic logic [31:0] pick_coord();
    logic [31:0] v;
    case ($urandom_range(0, 11))
      0: v = 32'h0000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h8000_0000;
      3: v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic queue_request(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    chunk_t c;
    request_queue.push_back('{opcode: op, x: x, y: y, z: z});
    if (op == OP_LOAD) begin
      if (loads_queued < SLOTS) begin
        c.x = x & ~LOW_MASK;
        c.y = y & ~LOW_MASK;
        c.z = z & ~LOW_MASK;
        loaded_chunks.push_back(c);
      end
      loads_queued++;
    end
  endtask

  task automatic note_mismatch(string what, answer_t want, answer_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("[%0t] %s: expected ok=%0d slot=%0d offset=%0d, got ok=%0d slot=%0d offset=%0d",
               $time, what, want.ok, want.slot, want.offset, got.ok, got.slot, got.offset);
    end
  endtask

  // Sampling at the rising edge: predict accepted requests, check accepted results.
  always @(posedge clk) begin : result_check
    answer_t got;
    answer_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles,
               answers_due.size());
      $display("end of test: mismatches");
      $finish;
    end else if (rst) begin
      req_taken <= 1'b0;
      resp_taken <= 1'b0;
    end else begin
      req_taken <= s_tvalid && s_tready;
      resp_taken <= m_tvalid && m_tready;
      if (s_tvalid && s_tready) begin
        answers_due.push_back(access_table(s_tuser[0], s_tdata));
        words_sent++;
      end
      if (m_tvalid && m_tready) begin
        words_seen++;
        got.ok = m_tuser[0];
        got.slot = m_tdata[SLOT_W-1:0];
        got.offset = m_tdata[SLOT_W+OFFSET_W-1:SLOT_W];
        if (answers_due.size() == 0) begin
          note_mismatch("result word with none expected", '0, got);
        end else begin
          want = answers_due.pop_front();
          if (got.ok !== want.ok || got.slot !== want.slot || got.offset !== want.offset) begin
            note_mismatch($sformatf("result word %0d", words_seen - 1), want, got);
          end
        end
      end
    end
  end

  // Request driver: one word at a time from the queue, with a random gap between words.
  // Every third block of 48 words goes out back to back.
  always @(negedge clk) begin
    if (!rst) begin
      if (req_taken) req_held = 1'b0;
      if (!req_held) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (request_queue.size() > 0) begin
          req_now = request_queue.pop_front();
          req_held = 1'b1;
          req_gap = ((words_sent / 48) % 3 == 1) ? 0 : $urandom_range(0, 6);
        end
      end
      s_tvalid <= req_held;
      s_tdata <= {req_now.z, req_now.y, req_now.x};
      s_tuser <= req_now.opcode;
    end
  end

  // Result side: after each accepted word the receiver stalls for a random count.
  always @(negedge clk) begin
    if (!rst) begin
      if (resp_taken) resp_stall = ((words_seen / 40) % 3 == 2) ? 0 : $urandom_range(0, 6);
      if (resp_stall > 0) begin
        resp_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    chunk_t c;
    int     pick;
    int     bitpos;
    int     coord;

    // Directed part: empty table, coordinate extremes, chunk edges and duplicates.
    queue_request(OP_LOOKUP, 32'd0, 32'd0, 32'd0);
    queue_request(OP_LOAD,   32'd0, 32'd0, 32'd0);
    queue_request(OP_LOOKUP, 32'd15, 32'd15, 32'd15);
    queue_request(OP_LOOKUP, 32'd0, 32'd0, 32'd0);
    queue_request(OP_LOOKUP, 32'd16, 32'd0, 32'd0);
    queue_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 32'd0);
    queue_request(OP_LOAD,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_request(OP_LOOKUP, 32'h8000_0005, 32'h8000_000A, 32'h8000_000F);
    queue_request(OP_LOAD,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_request(OP_LOOKUP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_request(OP_LOOKUP, 32'h7FFF_FFF0, 32'h7FFF_FFF0, 32'h7FFF_FFF0);
    queue_request(OP_LOAD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(OP_LOOKUP, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFF8);
    // Same chunk loaded twice: the lookup must report the lower slot.
    queue_request(OP_LOAD,   32'd3, 32'd7, 32'd9);
    queue_request(OP_LOOKUP, 32'd9, 32'd2, 32'd5);
    queue_request(OP_LOAD,   32'd0, 32'd0, 32'd16);
    queue_request(OP_LOOKUP, 32'd1, 32'd2, 32'd17);
    queue_request(OP_LOOKUP, 32'd0, 32'd16, 32'd0);
    queue_request(OP_LOAD,   32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFF0);
    queue_request(OP_LOOKUP, 32'h1234_567F, 32'h8000_000F, 32'h7FFF_FFF0);
    queue_request(OP_LOOKUP, 32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFF0);

    // Random part: mostly lookups aimed at loaded chunks, loads sparse enough that the
    // table fills part way through and later loads are refused.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        if (loaded_chunks.size() > 0 && $urandom_range(0, 2) == 0) begin
          c = loaded_chunks[$urandom_range(0, loaded_chunks.size() - 1)];
          queue_request(OP_LOAD, c.x | ($urandom & LOW_MASK), c.y | ($urandom & LOW_MASK),
                        c.z | ($urandom & LOW_MASK));
        end else begin
          queue_request(OP_LOAD, pick_coord(), pick_coord(), pick_coord());
        end
      end else if (loaded_chunks.size() > 0 && pick < 70) begin
        c = loaded_chunks[$urandom_range(0, loaded_chunks.size() - 1)];
        queue_request(OP_LOOKUP, c.x | ($urandom & LOW_MASK), c.y | ($urandom & LOW_MASK),
                      c.z | ($urandom & LOW_MASK));
      end else if (loaded_chunks.size() > 0 && pick < 82) begin
        // Near miss: one chunk coordinate bit flipped.
        c = loaded_chunks[$urandom_range(0, loaded_chunks.size() - 1)];
        bitpos = $urandom_range($clog2(EDGE), 31);
        coord = $urandom_range(0, 2);
        if (coord == 0) c.x[bitpos] = ~c.x[bitpos];
        else if (coord == 1) c.y[bitpos] = ~c.y[bitpos];
        else c.z[bitpos] = ~c.z[bitpos];
        queue_request(OP_LOOKUP, c.x | ($urandom & LOW_MASK), c.y | ($urandom & LOW_MASK),
                      c.z | ($urandom & LOW_MASK));
      end else begin
        queue_request(OP_LOOKUP, pick_coord(), pick_coord(), pick_coord());
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_queue.size() > 0 || req_held) @(posedge clk);
    while (answers_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d loads (%0d refused on a full table) and %0d lookups (%0d hits)",
             n_load, n_full, n_lookup, n_hit);
    $display("%0d result words checked in %0d cycles, %0d mismatches",
             words_seen, cycles, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: chunk_slot_table_top.f
hdl/cst_pkg.sv
hdl/cst_ram.sv
hdl/chunk_slot_table_top.sv
tb/sv/testbench.sv
